// ----- hdl/arrpq_pkg.sv -----
// Package for the array min-priority queue: request/result structs, codes,
// controller state type and the controller/datapath command and status groups.
// No dependencies.
package arrpq_pkg;

    localparam int DEPTH_DEFAULT = 16;
    localparam int DATA_W        = 32;
    localparam int OCC_W         = 5;

    localparam logic OP_INSERT = 1'b0;
    localparam logic OP_REMOVE = 1'b1;

    localparam logic [1:0] STATUS_OK    = 2'd0;
    localparam logic [1:0] STATUS_FULL  = 2'd1;
    localparam logic [1:0] STATUS_EMPTY = 2'd2;

    typedef struct packed {
        logic                     opcode;
        logic signed [DATA_W-1:0] value;
    } in_item_t;

    typedef struct packed {
        logic signed [DATA_W-1:0] removed_value;
        logic [1:0]               status;
        logic [OCC_W-1:0]         occupancy;
    } out_item_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_SHIFT,
        ST_DONE
    } ctrl_state_t;

    typedef struct packed {
        logic load;
        logic scan_step;
        logic shift_init;
        logic shift_step;
        logic finish;
    } dp_cmd_t;

    typedef struct packed {
        logic empty;
        logic sweep_done;
        logic out_free;
    } dp_sts_t;

endpackage

// ----- hdl/arrpq_ctrl.sv -----
// Controller FSM for the array min-priority queue: sequences load, scan,
// shift and finish. Depends on arrpq_pkg.
module arrpq_ctrl (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  logic                 req_opcode,
    input  arrpq_pkg::dp_sts_t   sts,
    output arrpq_pkg::dp_cmd_t   cmd
);
    import arrpq_pkg::*;

    ctrl_state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_ready    = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.load = 1'b1;
                    if (req_opcode == OP_REMOVE && !sts.empty) begin
                        state_next = ST_SCAN;
                    end else begin
                        state_next = ST_DONE;
                    end
                end
            end
            ST_SCAN: begin
                if (sts.sweep_done) begin
                    cmd.shift_init = 1'b1;
                    state_next     = ST_SHIFT;
                end else begin
                    cmd.scan_step = 1'b1;
                end
            end
            ST_SHIFT: begin
                if (sts.sweep_done) begin
                    state_next = ST_DONE;
                end else begin
                    cmd.shift_step = 1'b1;
                end
            end
            ST_DONE: begin
                // hold until the result register can take the result
                if (sts.out_free) begin
                    cmd.finish = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

// ----- hdl/arrpq_datapath.sv -----
// Datapath for the array min-priority queue: entry memory, count, scan and
// shift pointers, running minimum and the result register. Depends on arrpq_pkg.
module arrpq_datapath #(
    parameter int DEPTH = arrpq_pkg::DEPTH_DEFAULT
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  arrpq_pkg::in_item_t  s_data,
    input  arrpq_pkg::dp_cmd_t   cmd,
    output arrpq_pkg::dp_sts_t   sts,
    output logic                 m_valid,
    input  logic                 m_ready,
    output arrpq_pkg::out_item_t m_data
);
    import arrpq_pkg::*;

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    logic signed [DATA_W-1:0] mem [DEPTH];

    logic [CW-1:0]            count_reg, count_next;
    logic [CW-1:0]            idx_reg, idx_next;
    logic                     pend_reg, pend_next;
    logic [AW-1:0]            pend_idx_reg, pend_idx_next;
    logic [AW-1:0]            best_reg, best_next;
    logic signed [DATA_W-1:0] min_reg, min_next;
    logic                     op_reg;
    logic signed [DATA_W-1:0] val_reg;
    logic signed [DATA_W-1:0] rd_data_reg;
    logic                     m_valid_reg, m_valid_next;
    out_item_t                out_reg, out_next;

    logic                     full, empty, idx_below;
    logic                     rd_en, wr_en;
    logic [AW-1:0]            wr_addr;
    logic signed [DATA_W-1:0] wr_data;
    logic [CW+OCC_W-1:0]      occ_ext;

    assign full      = (count_reg == CW'(DEPTH));
    assign empty     = (count_reg == '0);
    assign idx_below = (idx_reg < count_reg);
    assign rd_en     = (cmd.scan_step || cmd.shift_step) && idx_below;

    assign sts.empty      = empty;
    assign sts.sweep_done = (idx_reg == count_reg) && !pend_reg;
    assign sts.out_free   = !m_valid_reg || m_ready;

    assign m_valid = m_valid_reg;
    assign m_data  = out_reg;

    always_comb begin
        idx_next      = idx_reg;
        pend_next     = rd_en;
        pend_idx_next = pend_idx_reg;
        best_next     = best_reg;
        min_next      = min_reg;
        count_next    = count_reg;
        wr_en         = 1'b0;
        wr_addr       = pend_idx_reg - AW'(1);
        wr_data       = rd_data_reg;
        m_valid_next  = m_valid_reg && !m_ready;
        out_next      = out_reg;

        if (cmd.load) begin
            idx_next = '0;
        end else if (cmd.shift_init) begin
            idx_next = CW'(best_reg) + CW'(1);
        end else if (rd_en) begin
            idx_next = idx_reg + CW'(1);
        end
        if (rd_en) begin
            pend_idx_next = idx_reg[AW-1:0];
        end

        // first entry seeds the minimum; strict less keeps the oldest on ties
        if (cmd.scan_step && pend_reg) begin
            if (pend_idx_reg == '0 || rd_data_reg < min_reg) begin
                min_next  = rd_data_reg;
                best_next = pend_idx_reg;
            end
        end

        // move each later entry down by one place
        if (cmd.shift_step && pend_reg) begin
            wr_en = 1'b1;
        end

        if (cmd.finish) begin
            out_next.removed_value = '0;
            out_next.status        = STATUS_OK;
            if (op_reg == OP_INSERT) begin
                if (full) begin
                    out_next.status = STATUS_FULL;
                end else begin
                    wr_en      = 1'b1;
                    wr_addr    = count_reg[AW-1:0];
                    wr_data    = val_reg;
                    count_next = count_reg + CW'(1);
                end
            end else begin
                if (empty) begin
                    out_next.status = STATUS_EMPTY;
                end else begin
                    out_next.removed_value = min_reg;
                    count_next             = count_reg - CW'(1);
                end
            end
            m_valid_next = 1'b1;
        end

        occ_ext            = {{OCC_W{1'b0}}, count_next};
        if (cmd.finish) begin
            out_next.occupancy = occ_ext[OCC_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[idx_reg[AW-1:0]];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg   <= '0;
            pend_reg    <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            count_reg   <= count_next;
            pend_reg    <= pend_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            op_reg  <= s_data.opcode;
            val_reg <= s_data.value;
        end
        idx_reg      <= idx_next;
        pend_idx_reg <= pend_idx_next;
        best_reg     <= best_next;
        min_reg      <= min_next;
        out_reg      <= out_next;
    end

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CW'(DEPTH))
        else $error("occupancy exceeds depth");

    a_remove_dec: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.finish && op_reg == OP_REMOVE && !empty)
        |=> count_reg == $past(count_reg) - CW'(1))
        else $error("successful remove did not drop occupancy by one");

    a_shift_addr: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.shift_step && pend_reg) |-> pend_idx_reg != '0)
        else $error("shift write below entry zero");

    a_load_idle_out: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.finish |=> m_valid_reg)
        else $error("finished request did not present a result");

endmodule

// ----- hdl/array_min_priority_queue_core.sv -----
// Min-priority queue kept in an unsorted array of DEPTH signed 32-bit entries.
// An insert presents its result from ST_DONE once the result register is free,
// and the next request can then be accepted. A remove on stored entries scans
// for the minimum, moves the later entries down and then finishes in ST_DONE;
// the scan and the shift each handle one entry at a time through the single read
// port and single write port of the entry memory. The next request is accepted
// while a result still waits in the output register. No clearing pass runs
// after reset. Depends on arrpq_pkg, arrpq_ctrl and arrpq_datapath.
module array_min_priority_queue_core #(
    parameter int DEPTH = arrpq_pkg::DEPTH_DEFAULT
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  arrpq_pkg::in_item_t  s_data,
    output logic                 m_valid,
    input  logic                 m_ready,
    output arrpq_pkg::out_item_t m_data
);
    import arrpq_pkg::*;

    dp_cmd_t cmd;
    dp_sts_t sts;

    arrpq_ctrl u_ctrl (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .req_opcode (s_data.opcode),
        .sts        (sts),
        .cmd        (cmd)
    );

    arrpq_datapath #(
        .DEPTH (DEPTH)
    ) u_datapath (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_data  (s_data),
        .cmd     (cmd),
        .sts     (sts),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

endmodule

// ----- tb/array_min_priority_queue_core_test.sv -----
// Self-checking testbench for the array min-priority queue core: drives insert and
// remove requests, predicts every result and compares it field by field.
// Depends on arrpq_pkg and array_min_priority_queue_core.
module array_min_priority_queue_core_test;
    timeunit 1ns;
    timeprecision 1ps;

    import arrpq_pkg::*;

    localparam int QUEUE_DEPTH     = 16;
    localparam int CLK_HALF        = 5;
    localparam int RESET_CYCLES    = 11;
    localparam int PHASE_REQUESTS  = 575;
    localparam int HOLD_OFF_CYCLES = 400;
    localparam int STALL_LIMIT     = 3000;
    localparam int DRAIN_CYCLES    = 60;
    localparam int MAX_PRINTED     = 50;

    logic      aclk    = 1'b0;
    logic      aresetn = 1'b0;
    logic      s_valid = 1'b0;
    logic      s_ready;
    in_item_t  s_data  = '0;
    logic      m_valid;
    logic      m_ready = 1'b0;
    out_item_t m_data;

    // Predicted queue contents, in stored order.
    logic signed [DATA_W-1:0] pq_entries [QUEUE_DEPTH];
    int        pq_count = 0;

    in_item_t  queued_ops [$];
    out_item_t predicted_results [$];

    int  sender_idle_pct   = 11;
    int  receiver_idle_pct = 87;
    bit  hold_off_start    = 1'b0;
    bit  hold_off_taken    = 1'b0;
    int  hold_off_left     = 0;
    int  mismatch_count    = 0;
    int  stall_cycles      = 0;

    array_min_priority_queue_core #(
        .DEPTH(QUEUE_DEPTH)
    ) u_dut (
        .aclk   (aclk),
        .aresetn(aresetn),
        .s_valid(s_valid),
        .s_ready(s_ready),
        .s_data (s_data),
        .m_valid(m_valid),
        .m_ready(m_ready),
        .m_data (m_data)
    );

    always #CLK_HALF aclk = ~aclk;

    function automatic out_item_t pq_apply(in_item_t req);
        out_item_t res;
        int        min_idx;
        res        = '0;
        res.status = STATUS_OK;
        if (req.opcode == OP_INSERT) begin
            if (pq_count >= QUEUE_DEPTH) begin
                res.status = STATUS_FULL;
            end else begin
                pq_entries[pq_count] = req.value;
                pq_count++;
            end
        end else if (pq_count == 0) begin
            res.status = STATUS_EMPTY;
        end else begin
            // strict less-than keeps the oldest entry on ties
            min_idx = 0;
            for (int i = 1; i < pq_count; i++) begin
                if (pq_entries[i] < pq_entries[min_idx]) begin
                    min_idx = i;
                end
            end
            res.removed_value = pq_entries[min_idx];
            for (int i = min_idx; i + 1 < pq_count; i++) begin
                pq_entries[i] = pq_entries[i + 1];
            end
            pq_count--;
        end
        res.occupancy = pq_count[OCC_W-1:0];
        return res;
    endfunction

    task automatic push_op(logic op, logic [DATA_W-1:0] val);
        in_item_t req;
        req.opcode = op;
        req.value  = val;
        queued_ops.push_back(req);
    endtask

    function automatic logic [DATA_W-1:0] pick_value();
        logic [DATA_W-1:0] val;
        case ($urandom_range(0, 5))
            0, 1: val = $urandom;
            // narrow range forces equal minima
            2: val = $urandom_range(0, 6) - 3;
            3: begin
                case ($urandom_range(0, 3))
                    0: val = 32'h8000_0000;
                    1: val = 32'h7FFF_FFFF;
                    2: val = '0;
                    default: val = '1;
                endcase
            end
            4: val = $urandom >> $urandom_range(0, 31);
            default: val = 32'h8000_0000 + $urandom_range(0, 3);
        endcase
        return val;
    endfunction

    task automatic queue_directed_requests();
        push_op(OP_REMOVE, 32'h0000_1234);
        push_op(OP_INSERT, 32'd5);
        push_op(OP_INSERT, 32'h7FFF_FFFF);
        push_op(OP_INSERT, 32'h8000_0000);
        push_op(OP_INSERT, 32'h0000_0000);
        push_op(OP_INSERT, 32'hFFFF_FFFF);
        push_op(OP_INSERT, 32'd5);
        push_op(OP_INSERT, 32'h8000_0000);
        push_op(OP_INSERT, 32'd1);
        push_op(OP_INSERT, 32'hFFFF_FFFE);
        push_op(OP_INSERT, 32'h5555_5555);
        push_op(OP_INSERT, 32'hAAAA_AAAA);
        push_op(OP_INSERT, 32'd3);
        push_op(OP_INSERT, 32'd3);
        push_op(OP_INSERT, 32'hFFFF_FFFF);
        push_op(OP_INSERT, 32'h7FFF_FFFE);
        push_op(OP_INSERT, 32'h8000_0001);
        // queue is full here
        push_op(OP_INSERT, 32'd9);
        push_op(OP_REMOVE, 32'hFFFF_FFFF);
        push_op(OP_REMOVE, 32'h0000_0000);
        push_op(OP_REMOVE, 32'h8000_0000);
        push_op(OP_REMOVE, 32'h7FFF_FFFF);
        push_op(OP_REMOVE, 32'h5A5A_5A5A);
        push_op(OP_REMOVE, 32'hA5A5_A5A5);
    endtask

    // Bursts lean toward insert or remove so occupancy sweeps between empty and full.
    task automatic queue_random_requests(int count);
        int insert_pct;
        int burst_left;
        insert_pct = 50;
        burst_left = 0;
        for (int n = 0; n < count; n++) begin
            if (burst_left == 0) begin
                burst_left = $urandom_range(8, 28);
                case ($urandom_range(0, 2))
                    0: insert_pct = 80;
                    1: insert_pct = 25;
                    default: insert_pct = 55;
                endcase
            end
            burst_left--;
            if ($urandom_range(0, 99) < insert_pct) begin
                push_op(OP_INSERT, pick_value());
            end else begin
                push_op(OP_REMOVE, $urandom);
            end
        end
    endtask

    task automatic report_mismatch(string field, logic [DATA_W-1:0] want,
                                   logic [DATA_W-1:0] got);
        if (mismatch_count < MAX_PRINTED) begin
            $display("tb: mismatch in %s at %0t: expected %0h, got %0h",
                     field, $realtime, want, got);
        end
        mismatch_count++;
    endtask

    // Request driver.
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            if (s_valid && s_ready) begin
                predicted_results.push_back(pq_apply(s_data));
            end
            if (!s_valid || s_ready) begin
                if (queued_ops.size() != 0 && $urandom_range(0, 99) >= sender_idle_pct) begin
                    s_data  <= queued_ops.pop_front();
                    s_valid <= 1'b1;
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // Result monitor and receiver back-pressure.
    always @(posedge aclk) begin
        out_item_t want;
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                if (predicted_results.size() == 0) begin
                    report_mismatch("unrequested result", '0, m_data.removed_value);
                end else begin
                    want = predicted_results.pop_front();
                    if (m_data.removed_value !== want.removed_value) begin
                        report_mismatch("removed_value", want.removed_value,
                                        m_data.removed_value);
                    end
                    if (m_data.status !== want.status) begin
                        report_mismatch("status", DATA_W'(want.status),
                                        DATA_W'(m_data.status));
                    end
                    if (m_data.occupancy !== want.occupancy) begin
                        report_mismatch("occupancy", DATA_W'(want.occupancy),
                                        DATA_W'(m_data.occupancy));
                    end
                end
            end
            if (hold_off_start && !hold_off_taken) begin
                hold_off_taken = 1'b1;
                hold_off_left  = HOLD_OFF_CYCLES;
                m_ready <= 1'b0;
            end else if (hold_off_left > 0) begin
                // hold results back so the core backs up and drops s_ready
                hold_off_left--;
                m_ready <= 1'b0;
            end else begin
                m_ready <= ($urandom_range(0, 99) >= receiver_idle_pct);
            end
        end
    end

    // Watchdog: count busy cycles without any handshake.
    always @(posedge aclk) begin
        if (aresetn && (queued_ops.size() != 0 || s_valid || predicted_results.size() != 0)
                && !(s_valid && s_ready) && !(m_valid && m_ready)) begin
            stall_cycles++;
            if (stall_cycles >= STALL_LIMIT) begin
                $display("tb: failure");
                $finish;
            end
        end else begin
            stall_cycles = 0;
        end
    end

    initial begin
        queue_directed_requests();
        queue_random_requests(PHASE_REQUESTS);
        repeat (RESET_CYCLES) @(posedge aclk);
        aresetn <= 1'b1;

        do @(negedge aclk); while (queued_ops.size() != 0);
        sender_idle_pct   = 87;
        receiver_idle_pct = 11;
        queue_random_requests(PHASE_REQUESTS);

        do @(negedge aclk); while (queued_ops.size() != 0);
        sender_idle_pct   = 0;
        receiver_idle_pct = 0;
        hold_off_start    = 1'b1;
        queue_random_requests(PHASE_REQUESTS);

        do @(negedge aclk);
        while (queued_ops.size() != 0 || s_valid || predicted_results.size() != 0);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        if (mismatch_count == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule
